/* hw/rtl/cpd_pkg.sv */
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants of the packet deframer and link monitor.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned MISS_W  = 3;
    localparam int unsigned REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_START_MARKER    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_READ_COUNT_CODE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VERSION_CODE    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_CODE      = 2'd3;

    localparam logic [BYTE_W-1:0] RST_START_MARKER    = 8'd170;
    localparam logic [BYTE_W-1:0] RST_READ_COUNT_CODE = 8'd1;
    localparam logic [BYTE_W-1:0] RST_VERSION_CODE    = 8'd2;
    localparam logic [BYTE_W-1:0] RST_LIGHT_CODE      = 8'd3;

    typedef enum logic [1:0] {
        OP_PAYLOAD = 2'd0,
        OP_END     = 2'd1,
        OP_TICK    = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_CRC_LO  = 3'd5
    } t_phase;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] ptype;
        logic              good;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] read_count_code;
        logic [BYTE_W-1:0] version_code;
        logic [BYTE_W-1:0] light_code;
    } t_cfg;

    typedef struct packed {
        t_op               kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] packet_kind;
        logic              last;
        logic              crc_good;
        logic              link_up;
        logic              send_version_request;
        logic [MISS_W-1:0] missed_now;
    } t_result;

endpackage

/* hw/rtl/crc_packet_deframer_link_monitor_unit.sv */
// ----------------------------------------------------------------------------
// crc_packet_deframer_link_monitor_unit
// Start byte / length / CRC-16/X-25 deframer with a link monitor.
// ----------------------------------------------------------------------------
// One request is taken per clock while full is low. The parser handles a
// request in the cycle it is taken and leaves a command in a queue of
// QUEUE_DEPTH entries; the link monitor takes one command per cycle, while the
// result register is empty or popped, into the result register. Start, type,
// length and CRC high bytes give no result. full rises only while the command
// queue is full, which happens when results are not popped. Registers sit on
// the APB port at byte addresses 0, 4, 8 and 12: start marker, read-count
// code, version code and light code.
module crc_packet_deframer_link_monitor_unit #(
    parameter int unsigned MISS_LIMIT  = 3,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_packet_kind,
    output logic        o_last,
    output logic        o_crc_good,
    output logic        o_link_up,
    output logic        o_send_version_request,
    output logic [2:0]  o_missed_now
);

    cpd_pkg::t_cfg      r_cfg;
    logic               cfg_wr;
    logic [cpd_pkg::REG_IDX_W-1:0] reg_idx;

    logic               front_valid;
    cpd_pkg::t_cmd      front_cmd;
    logic               q_empty;
    cpd_pkg::t_cmd      q_cmd;
    logic               back_take;
    cpd_pkg::t_result   result;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker    <= cpd_pkg::RST_START_MARKER;
            r_cfg.read_count_code <= cpd_pkg::RST_READ_COUNT_CODE;
            r_cfg.version_code    <= cpd_pkg::RST_VERSION_CODE;
            r_cfg.light_code      <= cpd_pkg::RST_LIGHT_CODE;
        end else if (cfg_wr) begin
            case (reg_idx)
                cpd_pkg::REG_START_MARKER:    r_cfg.start_marker    <= pwdata[7:0];
                cpd_pkg::REG_READ_COUNT_CODE: r_cfg.read_count_code <= pwdata[7:0];
                cpd_pkg::REG_VERSION_CODE:    r_cfg.version_code    <= pwdata[7:0];
                cpd_pkg::REG_LIGHT_CODE:      r_cfg.light_code      <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cpd_pkg::REG_START_MARKER:    prdata = {24'd0, r_cfg.start_marker};
            cpd_pkg::REG_READ_COUNT_CODE: prdata = {24'd0, r_cfg.read_count_code};
            cpd_pkg::REG_VERSION_CODE:    prdata = {24'd0, r_cfg.version_code};
            cpd_pkg::REG_LIGHT_CODE:      prdata = {24'd0, r_cfg.light_code};
            default:                      prdata = '0;
        endcase
    end

    cpd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_func         (i_func),
        .i_rx_byte      (i_rx_byte),
        .i_start_marker (r_cfg.start_marker),
        .o_cmd_valid    (front_valid),
        .o_cmd          (front_cmd)
    );

    cpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_valid),
        .i_wr_data (front_cmd),
        .i_rd      (back_take),
        .o_rd_data (q_cmd),
        .o_empty   (q_empty),
        .o_full    (full)
    );

    cpd_back #(
        .MISS_LIMIT (MISS_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_cmd),
        .i_cfg       (r_cfg),
        .o_cmd_take  (back_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_kind                 = result.kind;
    assign o_data_byte            = result.data_byte;
    assign o_packet_kind          = result.packet_kind;
    assign o_last                 = result.last;
    assign o_crc_good             = result.crc_good;
    assign o_link_up              = result.link_up;
    assign o_send_version_request = result.send_version_request;
    assign o_missed_now           = result.missed_now;

endmodule

/* hw/rtl/cpd_front.sv */
// ----------------------------------------------------------------------------
// cpd_front
// Packet parser: hunts for the start byte, tracks header, payload and CRC,
// and turns func, payload and CRC-low requests into link monitor commands.
// ----------------------------------------------------------------------------
module cpd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_full,
    input  logic                        i_func,
    input  logic [cpd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic [cpd_pkg::BYTE_W-1:0]  i_start_marker,
    output logic                        o_cmd_valid,
    output cpd_pkg::t_cmd               o_cmd
);

    localparam logic [cpd_pkg::CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [cpd_pkg::CRC_W-1:0] CRC_POLY = 16'h8408;

    function automatic logic [cpd_pkg::CRC_W-1:0] crc_feed(
        input logic [cpd_pkg::CRC_W-1:0]  crc_in,
        input logic [cpd_pkg::BYTE_W-1:0] b
    );
        logic [cpd_pkg::CRC_W-1:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    cpd_pkg::t_phase                r_phase, n_phase;
    logic [cpd_pkg::BYTE_W-1:0]     r_held_type, n_held_type;
    logic [cpd_pkg::BYTE_W-1:0]     r_bytes_left, n_bytes_left;
    logic [cpd_pkg::CRC_W-1:0]      r_crc, n_crc;
    logic [cpd_pkg::BYTE_W-1:0]     r_crc_hi, n_crc_hi;

    logic                           accept;
    logic [cpd_pkg::BYTE_W-1:0]     left_dec;
    logic [cpd_pkg::CRC_W-1:0]      crc_upd;

    assign accept   = i_push && !i_full;
    assign left_dec = r_bytes_left - 8'd1;
    assign crc_upd  = crc_feed(r_crc, i_rx_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= cpd_pkg::PH_HUNT;
            r_held_type  <= '0;
            r_bytes_left <= '0;
            r_crc        <= CRC_INIT;
            r_crc_hi     <= '0;
        end else begin
            r_phase      <= n_phase;
            r_held_type  <= n_held_type;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_crc_hi     <= n_crc_hi;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_held_type  = r_held_type;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_crc_hi     = r_crc_hi;
        o_cmd_valid  = 1'b0;
        o_cmd.op     = cpd_pkg::OP_TICK;
        o_cmd.data   = i_rx_byte;
        o_cmd.ptype  = r_held_type;
        o_cmd.good   = 1'b0;
        if (accept) begin
            if (i_func) begin
                o_cmd_valid = 1'b1;
            end else begin
                case (r_phase)
                    cpd_pkg::PH_HUNT: begin
                        if (i_rx_byte == i_start_marker) begin
                            n_crc   = crc_feed(CRC_INIT, i_rx_byte);
                            n_phase = cpd_pkg::PH_TYPE;
                        end
                    end
                    cpd_pkg::PH_TYPE: begin
                        n_held_type = i_rx_byte;
                        n_crc       = crc_upd;
                        n_phase     = cpd_pkg::PH_LEN;
                    end
                    cpd_pkg::PH_LEN: begin
                        n_bytes_left = i_rx_byte;
                        n_crc        = crc_upd;
                        n_phase      = (i_rx_byte == 8'd0) ? cpd_pkg::PH_CRC_HI
                                                          : cpd_pkg::PH_PAYLOAD;
                    end
                    cpd_pkg::PH_PAYLOAD: begin
                        n_crc        = crc_upd;
                        n_bytes_left = left_dec;
                        if (left_dec == 8'd0) begin
                            n_phase = cpd_pkg::PH_CRC_HI;
                        end
                        o_cmd_valid = 1'b1;
                        o_cmd.op    = cpd_pkg::OP_PAYLOAD;
                    end
                    cpd_pkg::PH_CRC_HI: begin
                        n_crc_hi = i_rx_byte;
                        n_phase  = cpd_pkg::PH_CRC_LO;
                    end
                    cpd_pkg::PH_CRC_LO: begin
                        o_cmd_valid = 1'b1;
                        o_cmd.op    = cpd_pkg::OP_END;
                        o_cmd.good  = ({r_crc_hi, i_rx_byte} == ~r_crc);
                        n_crc       = CRC_INIT;
                        n_phase     = cpd_pkg::PH_HUNT;
                    end
                    default: begin
                        n_phase = cpd_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

endmodule

/* hw/rtl/cpd_queue.sv */
// ----------------------------------------------------------------------------
// cpd_queue
// Short register queue of commands between the parser and the link monitor.
// ----------------------------------------------------------------------------
module cpd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  cpd_pkg::t_cmd i_wr_data,
    input  logic          i_rd,
    output cpd_pkg::t_cmd o_rd_data,
    output logic          o_empty,
    output logic          o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cpd_pkg::t_cmd      r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    logic do_wr, do_rd;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_FULL);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* hw/rtl/cpd_back.sv */
// ----------------------------------------------------------------------------
// cpd_back
// Link monitor: applies commands to the connected flag and missed counter
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module cpd_back #(
    parameter int unsigned MISS_LIMIT = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  cpd_pkg::t_cmd     i_cmd,
    input  cpd_pkg::t_cfg     i_cfg,
    output logic              o_cmd_take,
    input  logic              i_pop,
    output logic              o_empty,
    output cpd_pkg::t_result  o_result
);

    localparam logic [cpd_pkg::MISS_W-1:0] MISS_LIM = cpd_pkg::MISS_W'(MISS_LIMIT);
    localparam logic [cpd_pkg::MISS_W-1:0] MISS_MAX = '1;

    logic                         r_connected, n_connected;
    logic [cpd_pkg::MISS_W-1:0]   r_missed, n_missed;
    logic                         r_out_valid, n_out_valid;
    cpd_pkg::t_result             r_out, n_out;

    logic known_type;

    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;
    assign o_cmd_take = i_cmd_valid && (!r_out_valid || i_pop);
    assign known_type = (i_cmd.ptype == i_cfg.read_count_code)
                     || (i_cmd.ptype == i_cfg.version_code)
                     || (i_cmd.ptype == i_cfg.light_code);

    always_comb begin
        n_connected = r_connected;
        n_missed    = r_missed;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        if (o_cmd_take) begin
            n_out_valid                  = 1'b1;
            n_out.kind                   = i_cmd.op;
            n_out.data_byte              = '0;
            n_out.packet_kind            = i_cmd.ptype;
            n_out.last                   = 1'b0;
            n_out.crc_good               = 1'b0;
            n_out.send_version_request   = 1'b0;
            case (i_cmd.op)
                cpd_pkg::OP_PAYLOAD: begin
                    n_out.data_byte = i_cmd.data;
                end
                cpd_pkg::OP_END: begin
                    n_out.last     = 1'b1;
                    n_out.crc_good = i_cmd.good;
                    if (i_cmd.good) begin
                        if (known_type) begin
                            n_missed = '0;
                        end
                        if (i_cmd.ptype == i_cfg.version_code) begin
                            n_connected = 1'b1;
                        end
                    end
                end
                default: begin
                    n_out.packet_kind          = '0;
                    n_out.send_version_request = !r_connected;
                    if (r_connected) begin
                        if (r_missed != MISS_MAX) begin
                            n_missed = r_missed + 1'b1;
                        end
                        if (r_missed >= MISS_LIM) begin
                            n_connected = 1'b0;
                        end
                    end
                end
            endcase
            n_out.link_up    = n_connected;
            n_out.missed_now = n_missed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connected <= 1'b0;
            r_missed    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_connected <= n_connected;
            r_missed    <= n_missed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
